/* rtl/adbc_pkg.sv */
// shared types and constants for the audio sample dma buffer cache
`default_nettype none
package adbc_pkg;

   localparam int NUM_BUFFERS_DEF   = 32;
   localparam int BUFFER_BYTES_DEF  = 2048;
   localparam int MESSAGE_SLOTS_DEF = 50;

   localparam logic [5:0] AVAIL_RESET = 6'd32;

   typedef struct packed {
      logic [31:0] sample_addr;
      logic [11:0] request_length;
      logic [31:0] current_frame;
   } req_type;

   typedef struct packed {
      logic [4:0]  buffer_index;
      logic [10:0] byte_offset;
      logic        was_hit;
      logic        dma_request;
      logic [31:0] dma_rom_addr;
      logic [5:0]  dma_slot;
      logic        no_buffer;
   } rsp_type;

endpackage
`default_nettype wire

/* rtl/adbc_ram.sv */
// generic single write port, single read port ram with registered read data
`default_nettype none
module adbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

/* rtl/audio_dma_buffer_cache.sv */
// flow: the item is registered, then the used list is read one entry per cycle through
// the single ram read port until a hit, a later start or the list end; otherwise a decide
// state fills a new buffer or falls back, and a link state points a walked one at it. the
// next item is taken once the result is registered, also while a result waits in it.
// synchronous reset (and any csr write) empties the used list, reloads the free
// list with buffers_available buffers and restarts the slot counter.
`default_nettype none
module audio_dma_buffer_cache
   import adbc_pkg::*;
#(
   parameter int NUM_BUFFERS   = NUM_BUFFERS_DEF,
   parameter int BUFFER_BYTES  = BUFFER_BYTES_DEF,
   parameter int MESSAGE_SLOTS = MESSAGE_SLOTS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_data,
   input  wire logic       csr_wr_en,
   input  wire logic [5:0] csr_wr_data
);

   localparam int AW   = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
   localparam int CW   = $clog2(NUM_BUFFERS + 1);
   localparam int CMPW = (CW > 6) ? CW : 6;
   localparam int SW   = (MESSAGE_SLOTS > 1) ? $clog2(MESSAGE_SLOTS) : 1;

   typedef struct packed {
      logic [AW-1:0] nxt;
      logic [31:0]   start;
      logic [31:0]   last_use;
   } entry_type;

   localparam int EW = $bits(entry_type);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_WALK   = 5'b00010,
      S_DECIDE = 5'b00100,
      S_LINK   = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   state_type     state_ff, state_in;
   logic [5:0]    avail_ff, avail_in;
   logic [CW-1:0] used_ff, used_in;
   logic [SW-1:0] fill_ff, fill_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic          have_last_ff, have_last_in;
   logic [AW-1:0] last_b_ff, last_b_in;
   entry_type     last_ent_ff, last_ent_in;
   req_type       req_ff, req_in;
   rsp_type       res_ff, res_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   entry_type     ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [EW-1:0] ram_rd_data;
   entry_type     ent;

   logic            req_accept;
   logic            start_gt;
   logic            hit;
   logic            walk_end;
   logic            free_none;
   logic [32:0]     req_end;
   logic [32:0]     buf_limit;
   logic [AW-1:0]   new_b;
   logic [CMPW-1:0] avail_w;
   logic [CMPW-1:0] avail_cap;

   adbc_ram #(
      .WIDTH (EW),
      .DEPTH (NUM_BUFFERS)
   ) u_buf_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign ent        = ram_rd_data;
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign start_gt  = ent.start > req_ff.sample_addr;
   assign req_end   = 33'(req_ff.sample_addr) + 33'(req_ff.request_length);
   assign buf_limit = 33'(ent.start) + 33'(BUFFER_BYTES);
   assign hit       = req_end <= buf_limit;
   assign walk_end  = (CW'(pos_ff + 1'b1) == used_ff);
   assign new_b     = AW'(used_ff);

   // buffers are popped in index order, so the used count is also the pop count
   assign avail_w   = CMPW'(avail_ff);
   assign avail_cap = (avail_w > CMPW'(NUM_BUFFERS)) ? CMPW'(NUM_BUFFERS) : avail_w;
   assign free_none = CMPW'(used_ff) >= avail_cap;

   always_comb begin
      state_in     = state_ff;
      avail_in     = avail_ff;
      used_in      = used_ff;
      fill_in      = fill_ff;
      head_in      = head_ff;
      pos_in       = pos_ff;
      cur_in       = cur_ff;
      have_last_in = have_last_ff;
      last_b_in    = last_b_ff;
      last_ent_in  = last_ent_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cur_ff;
      ram_wr_data  = ent;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = cur_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               req_in       = req_data;
               pos_in       = '0;
               have_last_in = 1'b0;
               cur_in       = head_ff;
               if (used_ff == '0) begin
                  state_in = S_DECIDE;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = head_ff;
                  state_in    = S_WALK;
               end
            end
         end
         S_WALK: begin
            if (start_gt) begin
               state_in = S_DECIDE;
            end else if (hit) begin
               // stamp the frame, keep link and start
               ram_wr_en            = 1'b1;
               ram_wr_addr          = cur_ff;
               ram_wr_data.nxt      = ent.nxt;
               ram_wr_data.start    = ent.start;
               ram_wr_data.last_use = req_ff.current_frame;
               res_in               = '0;
               res_in.buffer_index  = 5'(cur_ff);
               res_in.byte_offset   = 11'(req_ff.sample_addr - ent.start);
               res_in.was_hit       = 1'b1;
               state_in             = S_DONE;
            end else begin
               have_last_in = 1'b1;
               last_b_in    = cur_ff;
               last_ent_in  = ent;
               pos_in       = CW'(pos_ff + 1'b1);
               if (walk_end) begin
                  state_in = S_DECIDE;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = ent.nxt;
                  cur_in      = ent.nxt;
               end
            end
         end
         S_DECIDE: begin
            res_in             = '0;
            res_in.byte_offset = {10'b0, req_ff.sample_addr[0]};
            state_in           = S_DONE;
            if (free_none) begin
               res_in.no_buffer = 1'b1;
               if (have_last_ff) begin
                  res_in.buffer_index = 5'(last_b_ff);
               end else if (used_ff != '0) begin
                  res_in.buffer_index = 5'(head_ff);
               end
            end else begin
               ram_wr_en            = 1'b1;
               ram_wr_addr          = new_b;
               ram_wr_data.nxt      = have_last_ff ? last_ent_ff.nxt : head_ff;
               ram_wr_data.start    = {req_ff.sample_addr[31:1], 1'b0};
               ram_wr_data.last_use = req_ff.current_frame;
               res_in.buffer_index  = 5'(new_b);
               res_in.dma_request   = 1'b1;
               res_in.dma_rom_addr  = {req_ff.sample_addr[31:1], 1'b0};
               res_in.dma_slot      = 6'(fill_ff);
               fill_in = (fill_ff == SW'(MESSAGE_SLOTS - 1)) ? '0 : SW'(fill_ff + 1'b1);
               used_in = CW'(used_ff + 1'b1);
               cur_in  = new_b;
               if (have_last_ff) begin
                  state_in = S_LINK;
               end else begin
                  head_in = new_b;
               end
            end
         end
         S_LINK: begin
            // point the last walked buffer at the new one
            ram_wr_en            = 1'b1;
            ram_wr_addr          = last_b_ff;
            ram_wr_data.nxt      = cur_ff;
            ram_wr_data.start    = last_ent_ff.start;
            ram_wr_data.last_use = last_ent_ff.last_use;
            state_in             = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         avail_ff     <= AVAIL_RESET;
         used_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (csr_wr_en) begin
         avail_ff     <= csr_wr_data;
         used_ff      <= '0;
         fill_ff      <= '0;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end else begin
         state_ff     <= state_in;
         avail_ff     <= avail_in;
         used_ff      <= used_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff      <= head_in;
      pos_ff       <= pos_in;
      cur_ff       <= cur_in;
      have_last_ff <= have_last_in;
      last_b_ff    <= last_b_in;
      last_ent_ff  <= last_ent_in;
      req_ff       <= req_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

endmodule
`default_nettype wire

/* rtl/adbc_checker.sv */
// port-level checks for the audio sample dma buffer cache, bound to the top level
`default_nettype none
module adbc_checker
   import adbc_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire rsp_type    rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // every result is exactly one of hit, fill or fallback
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_data.was_hit, rsp_data.dma_request, rsp_data.no_buffer}))
      else $error("result kind not one-hot");

   // fill fields only on a fill
   a_fill_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.dma_request |->
         rsp_data.dma_rom_addr == 32'd0 && rsp_data.dma_slot == 6'd0)
      else $error("dma fields set without a fill");

   // a miss only reports the odd byte of the address, and the fill address is even
   a_miss_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.was_hit |->
         rsp_data.byte_offset[10:1] == 10'd0 && rsp_data.dma_rom_addr[0] == 1'b0)
      else $error("miss offset or fill address malformed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind audio_dma_buffer_cache adbc_checker u_adbc_checker (.*);
`default_nettype wire

/* bench/audio_dma_buffer_cache_tb.sv */
// self-checking bench for the audio sample dma buffer cache: directed table, then random items
module audio_dma_buffer_cache_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import adbc_pkg::*;

   localparam int N_BUF = NUM_BUFFERS_DEF;
   localparam logic [32:0] BUF_SPAN = 33'(BUFFER_BYTES_DEF);
   localparam int N_SLOTS = MESSAGE_SLOTS_DEF;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = N_BUF + 8;
   localparam int RANDOM_ITEMS = 600;
   localparam int PLAN_ROWS = 21;
   localparam int MAX_PRINTED = 100;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [5:0]   csr_val;
      logic         typed;
      req_type      req;
      rsp_type      want;
   } plan_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_wr_en = 1'b0;
   logic [5:0] csr_wr_data = '0;

   // predicted cache state
   logic [31:0] buf_start [N_BUF];
   logic [31:0] buf_last_use [N_BUF];
   logic [4:0]  used_list [$];
   logic [4:0]  free_list [$];
   int unsigned fill_slot;
   rsp_type     expected_rsp_q [$];

   int err_count = 0;
   int hit_count = 0;
   int fill_total = 0;
   int fallback_count = 0;
   int csr_count = 0;
   int items_sent = 0;
   int idle_run = 0;
   int stall_left = 0;
   bit calm = 1'b0;
   logic [31:0] phase_base = '0;

   // directed rows: typed expectations only where obvious, the rest are predicted
   plan_row_type plan_tab [PLAN_ROWS] = '{
      '{ROW_ITEM, 6'd0, 1'b1, '{32'h0000_0000, 12'd0, 32'h0000_0000},
        '{5'd0, 11'd0, 1'b0, 1'b1, 32'h0000_0000, 6'd0, 1'b0}},
      '{ROW_ITEM, 6'd0, 1'b1, '{32'h0000_07FF, 12'd1, 32'h0000_0005},
        '{5'd0, 11'h7FF, 1'b1, 1'b0, 32'h0000_0000, 6'd0, 1'b0}},
      // zero length right at the buffer end wraps the offset to zero
      '{ROW_ITEM, 6'd0, 1'b1, '{32'h0000_0800, 12'd0, 32'h0000_0006},
        '{5'd0, 11'd0, 1'b1, 1'b0, 32'h0000_0000, 6'd0, 1'b0}},
      '{ROW_ITEM, 6'd0, 1'b1, '{32'h0000_0801, 12'd1, 32'h0000_0007},
        '{5'd1, 11'd1, 1'b0, 1'b1, 32'h0000_0800, 6'd1, 1'b0}},
      '{ROW_ITEM, 6'd0, 1'b1, '{32'hFFFF_FFFF, 12'd2048, 32'hFFFF_FFFF},
        '{5'd2, 11'd1, 1'b0, 1'b1, 32'hFFFF_FFFE, 6'd2, 1'b0}},
      // end of request passes 2^32, hit test must not wrap
      '{ROW_ITEM, 6'd0, 1'b1, '{32'hFFFF_FFFF, 12'd1, 32'h1234_5678},
        '{5'd2, 11'd1, 1'b1, 1'b0, 32'h0000_0000, 6'd0, 1'b0}},
      '{ROW_ITEM, 6'd0, 1'b0, '{32'h0000_0400, 12'd2047, 32'h0000_00FF}, '0},
      '{ROW_ITEM, 6'd0, 1'b0, '{32'h5555_5555, 12'h555, 32'h5555_5555}, '0},
      '{ROW_ITEM, 6'd0, 1'b0, '{32'hAAAA_AAAA, 12'h2AA, 32'hAAAA_AAAA}, '0},
      '{ROW_ITEM, 6'd0, 1'b0, '{32'h0000_0000, 12'd2048, 32'h0000_0009}, '0},
      '{ROW_ITEM, 6'd0, 1'b0, '{32'h0000_07FE, 12'd0, 32'h0000_000A}, '0},
      '{ROW_CSR, 6'd1, 1'b0, '0, '0},
      '{ROW_ITEM, 6'd0, 1'b1, '{32'h0000_0100, 12'd4, 32'h0000_0001},
        '{5'd0, 11'd0, 1'b0, 1'b1, 32'h0000_0100, 6'd0, 1'b0}},
      // free list empty: fall back to the last buffer walked
      '{ROW_ITEM, 6'd0, 1'b1, '{32'h0000_2000, 12'd4, 32'h0000_0002},
        '{5'd0, 11'd0, 1'b0, 1'b0, 32'h0000_0000, 6'd0, 1'b1}},
      // free list empty and nothing walked: fall back to the first used buffer
      '{ROW_ITEM, 6'd0, 1'b1, '{32'h0000_0051, 12'd4, 32'h0000_0003},
        '{5'd0, 11'd1, 1'b0, 1'b0, 32'h0000_0000, 6'd0, 1'b1}},
      '{ROW_ITEM, 6'd0, 1'b1, '{32'h0000_0101, 12'd8, 32'h0000_0004},
        '{5'd0, 11'd1, 1'b1, 1'b0, 32'h0000_0000, 6'd0, 1'b0}},
      '{ROW_CSR, 6'd31, 1'b0, '0, '0},
      '{ROW_ITEM, 6'd0, 1'b1, '{32'h0000_3000, 12'd16, 32'h0000_0005},
        '{5'd0, 11'd0, 1'b0, 1'b1, 32'h0000_3000, 6'd0, 1'b0}},
      '{ROW_ITEM, 6'd0, 1'b0, '{32'h0000_1001, 12'd16, 32'h0000_0006}, '0},
      '{ROW_ITEM, 6'd0, 1'b0, '{32'h0000_1001, 12'h7FF, 32'h0000_0007}, '0},
      '{ROW_CSR, 6'd32, 1'b0, '0, '0}
   };

   audio_dma_buffer_cache i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void reload_buffers(input logic [5:0] avail);
      int n;
      n = (avail > N_BUF) ? N_BUF : int'(avail);
      used_list.delete();
      free_list.delete();
      for (int i = 0; i < n; i++) free_list.push_back(5'(i));
      fill_slot = 0;
   endfunction

   // walk the address-ordered used list, then hit, fill or fall back
   function automatic rsp_type lookup_buffer(input req_type r);
      rsp_type     o;
      logic [32:0] req_end;
      logic [4:0]  b;
      int          last;
      o = '0;
      last = -1;
      req_end = {1'b0, r.sample_addr} + 33'(r.request_length);
      for (int i = 0; i < used_list.size(); i++) begin
         b = used_list[i];
         if (buf_start[b] > r.sample_addr) break;
         if (req_end <= {1'b0, buf_start[b]} + BUF_SPAN) begin
            buf_last_use[b] = r.current_frame;
            o.buffer_index = b;
            o.byte_offset = 11'(r.sample_addr - buf_start[b]);
            o.was_hit = 1'b1;
            hit_count++;
            return o;
         end
         last = i;
      end
      o.byte_offset = {10'd0, r.sample_addr[0]};
      if (free_list.size() == 0) begin
         if (last >= 0) o.buffer_index = used_list[last];
         else if (used_list.size() > 0) o.buffer_index = used_list[0];
         o.no_buffer = 1'b1;
         fallback_count++;
         return o;
      end
      b = free_list.pop_front();
      used_list.insert(last + 1, b);
      buf_start[b] = {r.sample_addr[31:1], 1'b0};
      buf_last_use[b] = r.current_frame;
      o.buffer_index = b;
      o.dma_request = 1'b1;
      o.dma_rom_addr = buf_start[b];
      o.dma_slot = 6'(fill_slot);
      fill_slot = (fill_slot + 1) % N_SLOTS;
      fill_total++;
      return o;
   endfunction

   // mostly short gaps, a few long ones, none in calm phases
   function automatic int idle_len();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // requests mostly land inside or just past buffers that already exist
   function automatic req_type random_req();
      req_type     r;
      int unsigned mode;
      int unsigned off;
      logic [31:0] s;
      r.current_frame = $urandom;
      mode = $urandom_range(0, 99);
      if (used_list.size() != 0 && mode < 60) begin
         s = buf_start[used_list[$urandom_range(0, used_list.size() - 1)]];
         if (mode < 5) begin
            r.sample_addr = s + 32'(BUFFER_BYTES_DEF);
            r.request_length = '0;
         end else begin
            off = $urandom_range(0, BUFFER_BYTES_DEF - 1);
            r.sample_addr = s + off;
            if (mode < 45) r.request_length = 12'($urandom_range(0, BUFFER_BYTES_DEF - off));
            else r.request_length = 12'($urandom_range(0, BUFFER_BYTES_DEF));
         end
      end else if (mode < 88) begin
         r.sample_addr = phase_base + $urandom_range(0, 32'h6000);
         r.request_length = 12'($urandom_range(0, 600));
      end else begin
         r.sample_addr = $urandom;
         r.request_length = 12'($urandom_range(0, BUFFER_BYTES_DEF));
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      err_count++;
      if (err_count <= MAX_PRINTED)
         $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
   endtask

   task automatic drive_item(input req_type r, input logic typed, input rsp_type want);
      int      gap;
      rsp_type predicted;
      gap = idle_len();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted = lookup_buffer(r);
      expected_rsp_q.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   // only written with the block drained and quiet
   task automatic set_buffer_count(input logic [5:0] v);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      reload_buffers(v);
      csr_count++;
   endtask

   initial begin
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = idle_len();
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("unexpected item", 32'(rsp_data.buffer_index), '0);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.buffer_index !== want.buffer_index)
                  report_mismatch("buffer_index", 32'(rsp_data.buffer_index),
                                  32'(want.buffer_index));
               if (rsp_data.byte_offset !== want.byte_offset)
                  report_mismatch("byte_offset", 32'(rsp_data.byte_offset),
                                  32'(want.byte_offset));
               if (rsp_data.was_hit !== want.was_hit)
                  report_mismatch("was_hit", 32'(rsp_data.was_hit), 32'(want.was_hit));
               if (rsp_data.dma_request !== want.dma_request)
                  report_mismatch("dma_request", 32'(rsp_data.dma_request),
                                  32'(want.dma_request));
               if (rsp_data.dma_rom_addr !== want.dma_rom_addr)
                  report_mismatch("dma_rom_addr", rsp_data.dma_rom_addr, want.dma_rom_addr);
               if (rsp_data.dma_slot !== want.dma_slot)
                  report_mismatch("dma_slot", 32'(rsp_data.dma_slot), 32'(want.dma_slot));
               if (rsp_data.no_buffer !== want.no_buffer)
                  report_mismatch("no_buffer", 32'(rsp_data.no_buffer), 32'(want.no_buffer));
            end
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) idle_run = 0;
         else idle_run++;
         if (idle_run >= WATCHDOG_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
            $display("audio_dma_buffer_cache_tb: errors");
            $finish;
         end
      end
   end

   initial begin
      int         phase;
      int         first_random;
      logic [5:0] avail;
      reload_buffers(AVAIL_RESET);
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      foreach (plan_tab[i]) begin
         if (plan_tab[i].kind == ROW_CSR) set_buffer_count(plan_tab[i].csr_val);
         else drive_item(plan_tab[i].req, plan_tab[i].typed, plan_tab[i].want);
      end

      // random phases, each with a fresh buffer count and address window
      first_random = items_sent;
      phase = 0;
      while (items_sent - first_random < RANDOM_ITEMS) begin
         if (phase == 0) avail = 6'd32;
         else if (phase == 1) avail = 6'd1;
         else if ($urandom_range(0, 4) == 0) avail = ($urandom_range(0, 1) != 0) ? 6'd32 : 6'd1;
         else avail = 6'($urandom_range(1, 32));
         set_buffer_count(avail);
         calm = ($urandom_range(0, 3) == 0);
         phase_base = ($urandom_range(0, 5) == 0) ? 32'hFFFF_C000 : $urandom;
         repeat ($urandom_range(30, 90)) drive_item(random_req(), 1'b0, '0);
         phase++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      calm = 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d requests over %0d buffer-count writes", items_sent, csr_count);
      $display("outcomes: %0d hits, %0d fills, %0d no-buffer fallbacks",
               hit_count, fill_total, fallback_count);
      if (err_count == 0) begin
         $display("audio_dma_buffer_cache_tb: clean");
      end else begin
         $display("audio_dma_buffer_cache_tb: errors");
      end
      $finish;
   end

endmodule
